// File: sv/keyed_priority_task_table_core_assert.svh
// assertion macros used by the task table rtl
`ifndef KEYED_PRIORITY_TASK_TABLE_CORE_ASSERT_SVH
`define KEYED_PRIORITY_TASK_TABLE_CORE_ASSERT_SVH

`ifndef NO_ASSERTIONS
// condition must hold in the same cycle
`define KPTT_ASSERT_IMPLIES(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
// condition must hold in the following cycle
`define KPTT_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`else
`define KPTT_ASSERT_IMPLIES(label, clk, rst_n, ante, cons, msg)
`define KPTT_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg)
`endif

`endif

// File: sv/kptt_pkg.sv
// types and constants of the keyed priority task table
package kptt_pkg;

    localparam int CAPACITY_DEF = 64;
    localparam int CMD_W        = 2;
    localparam int STATUS_W     = 2;
    localparam int USER_W       = 16;
    localparam int TASK_W       = 16;
    localparam int PRIO_W       = 32;

    typedef enum logic [CMD_W-1:0] {
        CMD_ADD    = 2'd0,
        CMD_EDIT   = 2'd1,
        CMD_REMOVE = 2'd2,
        CMD_EXEC   = 2'd3
    } cmd_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK        = 2'd0,
        ST_NOT_FOUND = 2'd1,
        ST_FULL      = 2'd2,
        ST_EMPTY     = 2'd3
    } status_t;

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_SCAN,
        S_COMMIT,
        S_RESP
    } state_t;

    // one table slot as stored in the ram
    typedef struct packed {
        logic              valid;
        logic [USER_W-1:0] user;
        logic [TASK_W-1:0] task_id;
        logic [PRIO_W-1:0] prio;
    } entry_t;

    localparam int ENTRY_W = $bits(entry_t);

    // controller to datapath commands
    typedef struct packed {
        logic clear_wr;
        logic load_item;
        logic scan_start;
        logic scan_run;
        logic commit;
    } ctrl_cmd_t;

    // datapath to controller status
    typedef struct packed {
        logic clear_last;
        logic scan_last;
    } ctrl_stat_t;

endpackage

// File: sv/kptt_ram.sv
// generic simple dual port ram with registered read
module kptt_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    localparam int AW   = $clog2(DEPTH)
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // write port and registered read port
    always_ff @(posedge clk) begin
        if (we) begin
            mem_reg[waddr] <= wdata;
        end
        rdata_reg <= mem_reg[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// File: sv/kptt_ctrl.sv
// controller state machine of the task table
module kptt_ctrl (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   s_valid,
    output logic                   s_ready,
    output logic                   m_valid,
    input  logic                   m_ready,
    input  kptt_pkg::ctrl_stat_t   stat,
    output kptt_pkg::ctrl_cmd_t    cmd
);
    import kptt_pkg::*;

    state_t state_reg;
    state_t state_next;

    // state register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_CLEAR;
        end else begin
            state_reg <= state_next;
        end
    end

    // next state and command decode
    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        s_ready    = 1'b0;
        m_valid    = 1'b0;
        unique case (state_reg)
            S_CLEAR: begin
                cmd.clear_wr = 1'b1;
                if (stat.clear_last) begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    cmd.load_item  = 1'b1;
                    cmd.scan_start = 1'b1;
                    state_next     = S_SCAN;
                end
            end
            S_SCAN: begin
                cmd.scan_run = 1'b1;
                if (stat.scan_last) begin
                    state_next = S_COMMIT;
                end
            end
            S_COMMIT: begin
                cmd.commit = 1'b1;
                state_next = S_RESP;
            end
            S_RESP: begin
                m_valid = 1'b1;
                if (m_ready) begin
                    state_next = S_IDLE;
                end
            end
            default: begin
                state_next = S_CLEAR;
            end
        endcase
    end

endmodule

// File: sv/kptt_datapath.sv
// scan datapath: slot lookup, free slot and top selection, table update
module kptt_datapath #(
    parameter int CAPACITY = kptt_pkg::CAPACITY_DEF,
    localparam int IDX_W   = $clog2(CAPACITY)
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic [kptt_pkg::CMD_W-1:0]    s_cmd,
    input  logic [kptt_pkg::USER_W-1:0]   s_user_id,
    input  logic [kptt_pkg::TASK_W-1:0]   s_task_id,
    input  logic [kptt_pkg::PRIO_W-1:0]   s_priority_req,
    input  kptt_pkg::ctrl_cmd_t           cmd,
    output kptt_pkg::ctrl_stat_t          stat,
    output logic [kptt_pkg::STATUS_W-1:0] m_status,
    output logic [kptt_pkg::USER_W-1:0]   m_top_user,
    output logic                          ram_we,
    output logic [IDX_W-1:0]              ram_waddr,
    output logic [kptt_pkg::ENTRY_W-1:0]  ram_wdata,
    output logic [IDX_W-1:0]              ram_raddr,
    input  logic [kptt_pkg::ENTRY_W-1:0]  ram_rdata
);
    import kptt_pkg::*;

    localparam logic [IDX_W-1:0] LAST = IDX_W'(CAPACITY - 1);

    // captured word
    cmd_t              cmd_reg,  cmd_next;
    logic [USER_W-1:0] user_reg, user_next;
    logic [TASK_W-1:0] key_reg,  key_next;
    logic [PRIO_W-1:0] prio_reg, prio_next;

    // scan control
    logic [IDX_W-1:0]  addr_reg, addr_next;
    logic              issue_on_reg, issue_on_next;
    logic              data_valid_reg, data_valid_next;
    logic [IDX_W-1:0]  data_idx_reg, data_idx_next;

    // scan trackers
    logic              match_found_reg, match_found_next;
    logic [IDX_W-1:0]  match_idx_reg, match_idx_next;
    logic [USER_W-1:0] match_user_reg, match_user_next;
    logic              free_found_reg, free_found_next;
    logic [IDX_W-1:0]  free_idx_reg, free_idx_next;
    logic              best_found_reg, best_found_next;
    logic [IDX_W-1:0]  best_idx_reg, best_idx_next;
    logic [PRIO_W-1:0] best_prio_reg, best_prio_next;
    logic [TASK_W-1:0] best_task_reg, best_task_next;
    logic [USER_W-1:0] best_user_reg, best_user_next;

    // result word
    status_t           status_reg, status_next;
    logic [USER_W-1:0] top_user_reg, top_user_next;

    entry_t rd_entry;
    entry_t wr_entry;
    logic   better;

    assign rd_entry  = entry_t'(ram_rdata);
    assign ram_raddr = addr_reg;
    assign ram_wdata = wr_entry;

    assign stat.clear_last = (addr_reg == LAST);
    assign stat.scan_last  = data_valid_reg && (data_idx_reg == LAST);

    assign m_status   = status_reg;
    assign m_top_user = top_user_reg;

    // higher priority wins, then higher task id
    assign better = !best_found_reg ||
                    (rd_entry.prio > best_prio_reg) ||
                    ((rd_entry.prio == best_prio_reg) && (rd_entry.task_id > best_task_reg));

    // next state of the datapath and table write
    always_comb begin
        cmd_next         = cmd_reg;
        user_next        = user_reg;
        key_next         = key_reg;
        prio_next        = prio_reg;
        addr_next        = addr_reg;
        issue_on_next    = issue_on_reg;
        data_valid_next  = 1'b0;
        data_idx_next    = data_idx_reg;
        match_found_next = match_found_reg;
        match_idx_next   = match_idx_reg;
        match_user_next  = match_user_reg;
        free_found_next  = free_found_reg;
        free_idx_next    = free_idx_reg;
        best_found_next  = best_found_reg;
        best_idx_next    = best_idx_reg;
        best_prio_next   = best_prio_reg;
        best_task_next   = best_task_reg;
        best_user_next   = best_user_reg;
        status_next      = status_reg;
        top_user_next    = top_user_reg;
        ram_we           = 1'b0;
        ram_waddr        = addr_reg;
        wr_entry         = '0;

        // clearing pass after reset
        if (cmd.clear_wr) begin
            ram_we    = 1'b1;
            addr_next = (addr_reg == LAST) ? '0 : addr_reg + 1'b1;
        end

        // capture the word and arm the scan
        if (cmd.load_item) begin
            cmd_next  = cmd_t'(s_cmd);
            user_next = s_user_id;
            key_next  = s_task_id;
            prio_next = s_priority_req;
        end
        if (cmd.scan_start) begin
            addr_next       = '0;
            issue_on_next   = 1'b1;
            match_found_next = 1'b0;
            free_found_next = 1'b0;
            best_found_next = 1'b0;
        end

        // one read issued per cycle
        if (cmd.scan_run && issue_on_reg) begin
            data_valid_next = 1'b1;
            data_idx_next   = addr_reg;
            if (addr_reg == LAST) begin
                issue_on_next = 1'b0;
            end else begin
                addr_next = addr_reg + 1'b1;
            end
        end

        // evaluate the slot read in the previous cycle
        if (cmd.scan_run && data_valid_reg) begin
            if (rd_entry.valid && (rd_entry.task_id == key_reg) && !match_found_reg) begin
                match_found_next = 1'b1;
                match_idx_next   = data_idx_reg;
                match_user_next  = rd_entry.user;
            end
            if (!rd_entry.valid && !free_found_reg) begin
                free_found_next = 1'b1;
                free_idx_next   = data_idx_reg;
            end
            if (rd_entry.valid && better) begin
                best_found_next = 1'b1;
                best_idx_next   = data_idx_reg;
                best_prio_next  = rd_entry.prio;
                best_task_next  = rd_entry.task_id;
                best_user_next  = rd_entry.user;
            end
        end

        // apply the command and form the result
        if (cmd.commit) begin
            status_next   = ST_OK;
            top_user_next = '0;
            case (cmd_reg)
                CMD_ADD: begin
                    wr_entry.valid   = 1'b1;
                    wr_entry.user    = user_reg;
                    wr_entry.task_id = key_reg;
                    wr_entry.prio    = prio_reg;
                    if (match_found_reg) begin
                        ram_we    = 1'b1;
                        ram_waddr = match_idx_reg;
                    end else if (free_found_reg) begin
                        ram_we    = 1'b1;
                        ram_waddr = free_idx_reg;
                    end else begin
                        status_next = ST_FULL;
                    end
                end
                CMD_EDIT: begin
                    wr_entry.valid   = 1'b1;
                    wr_entry.user    = match_user_reg;
                    wr_entry.task_id = key_reg;
                    wr_entry.prio    = prio_reg;
                    ram_waddr        = match_idx_reg;
                    if (match_found_reg) begin
                        ram_we = 1'b1;
                    end else begin
                        status_next = ST_NOT_FOUND;
                    end
                end
                CMD_REMOVE: begin
                    ram_waddr = match_idx_reg;
                    if (match_found_reg) begin
                        ram_we = 1'b1;
                    end else begin
                        status_next = ST_NOT_FOUND;
                    end
                end
                default: begin
                    ram_waddr = best_idx_reg;
                    if (best_found_reg) begin
                        ram_we        = 1'b1;
                        top_user_next = best_user_reg;
                    end else begin
                        status_next = ST_EMPTY;
                    end
                end
            endcase
        end
    end

    // control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            addr_reg        <= '0;
            issue_on_reg    <= 1'b0;
            data_valid_reg  <= 1'b0;
            match_found_reg <= 1'b0;
            free_found_reg  <= 1'b0;
            best_found_reg  <= 1'b0;
        end else begin
            addr_reg        <= addr_next;
            issue_on_reg    <= issue_on_next;
            data_valid_reg  <= data_valid_next;
            match_found_reg <= match_found_next;
            free_found_reg  <= free_found_next;
            best_found_reg  <= best_found_next;
        end
    end

    // payload registers
    always_ff @(posedge aclk) begin
        cmd_reg        <= cmd_next;
        user_reg       <= user_next;
        key_reg        <= key_next;
        prio_reg       <= prio_next;
        data_idx_reg   <= data_idx_next;
        match_idx_reg  <= match_idx_next;
        match_user_reg <= match_user_next;
        free_idx_reg   <= free_idx_next;
        best_idx_reg   <= best_idx_next;
        best_prio_reg  <= best_prio_next;
        best_task_reg  <= best_task_next;
        best_user_reg  <= best_user_next;
        status_reg     <= status_next;
        top_user_reg   <= top_user_next;
    end

endmodule

// File: sv/keyed_priority_task_table_core.sv
// Flow: an accepted word runs through the scan and commit states, and m_valid
// rises in the response state; no new word is taken until m_ready takes that
// result. Every command scans all slots through the single read port of the
// table ram, one slot a cycle. Reset: synchronous, active low; afterwards a
// clearing pass marks every slot free while s_ready stays low.
// top level of the keyed priority task table
module keyed_priority_task_table_core #(
    parameter int CAPACITY = kptt_pkg::CAPACITY_DEF
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_valid,
    output logic                          s_ready,
    input  logic [kptt_pkg::CMD_W-1:0]    s_cmd,
    input  logic [kptt_pkg::USER_W-1:0]   s_user_id,
    input  logic [kptt_pkg::TASK_W-1:0]   s_task_id,
    input  logic [kptt_pkg::PRIO_W-1:0]   s_priority_req,
    output logic                          m_valid,
    input  logic                          m_ready,
    output logic [kptt_pkg::STATUS_W-1:0] m_status,
    output logic [kptt_pkg::USER_W-1:0]   m_top_user
);
    import kptt_pkg::*;

    `include "keyed_priority_task_table_core_assert.svh"

    localparam int IDX_W = $clog2(CAPACITY);

    ctrl_cmd_t          cmd;
    ctrl_stat_t         stat;
    logic               ram_we;
    logic [IDX_W-1:0]   ram_waddr;
    logic [ENTRY_W-1:0] ram_wdata;
    logic [IDX_W-1:0]   ram_raddr;
    logic [ENTRY_W-1:0] ram_rdata;

    // sequencer
    kptt_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .stat    (stat),
        .cmd     (cmd)
    );

    // scan and update logic
    kptt_datapath #(
        .CAPACITY (CAPACITY)
    ) u_datapath (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_cmd          (s_cmd),
        .s_user_id      (s_user_id),
        .s_task_id      (s_task_id),
        .s_priority_req (s_priority_req),
        .cmd            (cmd),
        .stat           (stat),
        .m_status       (m_status),
        .m_top_user     (m_top_user),
        .ram_we         (ram_we),
        .ram_waddr      (ram_waddr),
        .ram_wdata      (ram_wdata),
        .ram_raddr      (ram_raddr),
        .ram_rdata      (ram_rdata)
    );

    // task table storage
    kptt_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (CAPACITY)
    ) u_table (
        .clk   (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // checks
    `KPTT_ASSERT_IMPLIES(a_no_overlap, aclk, aresetn, m_valid, !s_ready, "ready while result pending")
    `KPTT_ASSERT_NEXT(a_busy_after_accept, aclk, aresetn, s_valid && s_ready, !s_ready, "second word taken")
    `KPTT_ASSERT_NEXT(a_single_result, aclk, aresetn, m_valid && m_ready, !m_valid, "result repeated")
    `KPTT_ASSERT_IMPLIES(a_user_zero, aclk, aresetn, m_valid && (m_status != ST_OK), m_top_user == '0, "user on failure")

endmodule
